### hw/rtl/assert_macros.svh
// assertion macros used by the rtl file that checks its own behavior
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### hw/rtl/hmap_pkg.sv
// shared types, constants and helpers of the linear probe hash map
// no dependencies; used by every module of the block
package hmap_pkg;

  // table geometry (slot count is a power of two, home slot is the low key bits)
  localparam int unsigned Slots     = 128;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned SlotBits  = $clog2(Slots);

  typedef logic [SlotBits-1:0] slot_idx_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_FOUND   = 3'd1,
    ST_MISSING = 3'd2,
    ST_REMOVED = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_USED    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_PROBE = 1'b1
  } state_e;

  // request beat
  typedef struct packed {
    req_e                        req_type;
    logic [KeyBits-1:0]          key;
    logic signed [ValueBits-1:0] value;
  } req_t;

  // result beat
  typedef struct packed {
    status_e                     status;
    logic signed [ValueBits-1:0] found_value;
  } rsp_t;

  // one table entry
  typedef struct packed {
    tag_e                        tag;
    logic [KeyBits-1:0]          key;
    logic signed [ValueBits-1:0] value;
  } slot_t;

  // compare unit flags for the slot under probe
  typedef struct packed {
    logic is_empty;
    logic is_hit;
    logic is_deleted;
  } match_t;

  function automatic slot_idx_t home_slot(input logic [KeyBits-1:0] key);
    return key[SlotBits-1:0];
  endfunction

  function automatic slot_idx_t next_slot(input slot_idx_t s);
    return (s == slot_idx_t'(Slots - 1)) ? '0 : s + slot_idx_t'(1);
  endfunction

endpackage

### hw/rtl/hmap_slot_mem.sv
// slot store: one entry per slot, one write and one registered read per cycle
// depends on hmap_pkg; per-slot valid bits make unwritten slots read as empty
module hmap_slot_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hmap_pkg::slot_idx_t rd_addr_i,
  output hmap_pkg::slot_t   rd_slot_o,
  input  logic              wr_en_i,
  input  hmap_pkg::slot_idx_t wr_addr_i,
  input  hmap_pkg::slot_t   wr_slot_i
);
  import hmap_pkg::*;

  slot_t             mem [Slots];
  slot_t             rd_data_q;
  logic [Slots-1:0]  valid_q;
  logic              rd_valid_q;

  // entry array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_slot_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // valid bits cleared at once by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // never-written slot reads as empty
  always_comb begin
    rd_slot_o = rd_data_q;
    if (!rd_valid_q) begin
      rd_slot_o.tag = TAG_EMPTY;
    end
  end

endmodule

### hw/rtl/hmap_match.sv
// compare unit shared by every probe step: tag decode and key compare
// depends on hmap_pkg
module hmap_match (
  input  hmap_pkg::slot_t               slot_i,
  input  logic [hmap_pkg::KeyBits-1:0]  key_i,
  output hmap_pkg::match_t              match_o
);
  import hmap_pkg::*;

  // key compare only counts on an occupied slot
  always_comb begin
    match_o.is_empty   = (slot_i.tag == TAG_EMPTY);
    match_o.is_hit     = (slot_i.tag == TAG_USED) && (slot_i.key == key_i);
    match_o.is_deleted = (slot_i.tag == TAG_DELETED);
  end

endmodule

### hw/rtl/hmap_ctrl.sv
// probe sequencer: walks the cluster one slot a cycle, then commits and answers
// depends on hmap_pkg; drives hmap_slot_mem and reads hmap_match flags
module hmap_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  hmap_pkg::req_t                req_i,
  output logic                          done_o,
  output hmap_pkg::rsp_t                rsp_o,
  output hmap_pkg::slot_idx_t           rd_addr_o,
  input  hmap_pkg::slot_t               rd_slot_i,
  input  hmap_pkg::match_t              match_i,
  output logic [hmap_pkg::KeyBits-1:0]  key_o,
  output logic                          wr_en_o,
  output hmap_pkg::slot_idx_t           wr_addr_o,
  output hmap_pkg::slot_t               wr_slot_o
);
  import hmap_pkg::*;

  state_e                      state_q, state_d;
  slot_idx_t                   cur_q, free_q, cnt_q;
  logic                        has_free_q;
  logic [KeyBits-1:0]          key_q;
  logic signed [ValueBits-1:0] val_q;
  req_e                        op_q;
  logic                        done_q, done_d;
  rsp_t                        rsp_q, rsp_d;

  logic      req_ok, accept, take_free, any_free, lap_end, probe_done;
  slot_idx_t free_sel;

  // request decode and probe step decisions
  always_comb begin
    req_ok     = (req_i.req_type == REQ_INSERT) || (req_i.req_type == REQ_SEARCH) ||
                 (req_i.req_type == REQ_REMOVE);
    accept     = (state_q == S_IDLE) && start_i;
    take_free  = !has_free_q && (match_i.is_empty || match_i.is_deleted);
    free_sel   = take_free ? cur_q : free_q;
    any_free   = has_free_q || take_free;
    lap_end    = (cnt_q == slot_idx_t'(Slots - 1));
    probe_done = match_i.is_empty || match_i.is_hit || lap_end;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && req_ok) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: read address, commit write, result beat
  always_comb begin
    rd_addr_o = next_slot(cur_q);
    wr_en_o   = 1'b0;
    wr_addr_o = cur_q;
    wr_slot_o = '{tag: TAG_USED, key: key_q, value: val_q};
    done_d    = 1'b0;
    rsp_d     = '{status: ST_MISSING, found_value: '0};
    unique case (state_q)
      S_IDLE: begin
        rd_addr_o = home_slot(req_i.key);
        // unused request code answers without a probe
        if (start_i && !req_ok) begin
          done_d = 1'b1;
        end
      end
      S_PROBE: begin
        if (probe_done) begin
          done_d = 1'b1;
          case (op_q)
            REQ_INSERT: begin
              if (match_i.is_hit) begin
                wr_en_o      = 1'b1;
                rsp_d.status = ST_STORED;
              end else if (any_free) begin
                wr_en_o      = 1'b1;
                wr_addr_o    = free_sel;
                rsp_d.status = ST_STORED;
              end else begin
                rsp_d.status = ST_FULL;
              end
            end
            REQ_SEARCH: begin
              if (match_i.is_hit) begin
                rsp_d.status      = ST_FOUND;
                rsp_d.found_value = rd_slot_i.value;
              end
            end
            REQ_REMOVE: begin
              if (match_i.is_hit) begin
                wr_en_o       = 1'b1;
                wr_slot_o.tag = TAG_DELETED;
                rsp_d.status  = ST_REMOVED;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      has_free_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (accept) begin
        cnt_q      <= '0;
        has_free_q <= 1'b0;
      end else if (state_q == S_PROBE && !probe_done) begin
        cnt_q <= cnt_q + slot_idx_t'(1);
        if (take_free) begin
          has_free_q <= 1'b1;
        end
      end
    end
  end

  // request and probe payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      cur_q <= home_slot(req_i.key);
      key_q <= req_i.key;
      val_q <= req_i.value;
      op_q  <= req_i.req_type;
    end else if (state_q == S_PROBE && !probe_done) begin
      cur_q <= next_slot(cur_q);
      if (take_free) begin
        free_q <= cur_q;
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign key_o  = key_q;

endmodule

### hw/rtl/linear_probe_hash_map_core.sv
// linear probe hash map: each request probes one slot at a time, from the home
// slot up to the first empty slot or the key (one lap of 128 at most), then a
// registered result beat follows; an unused request code answers without a probe.
// the slot store reads one slot per cycle, which sets the probe rate; busy stays
// high until the result beat, when the next request may already start.
// reset (rst_ni, async, active low) marks all slots empty at once; results cannot stall.
`include "assert_macros.svh"

module linear_probe_hash_map_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  hmap_pkg::req_t  req_i,
  output logic            done_o,
  output hmap_pkg::rsp_t  rsp_o
);
  import hmap_pkg::*;

  slot_idx_t          rd_addr, wr_addr;
  slot_t              rd_slot, wr_slot;
  logic               wr_en;
  match_t             match;
  logic [KeyBits-1:0] probe_key;
  logic               probe_start, value_ok;

  // sequencer
  hmap_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .rd_addr_o (rd_addr),
    .rd_slot_i (rd_slot),
    .match_i   (match),
    .key_o     (probe_key),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_slot_o (wr_slot)
  );

  // slot store
  hmap_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_slot_o (rd_slot),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_slot_i (wr_slot)
  );

  // compare unit
  hmap_match u_match (
    .slot_i  (rd_slot),
    .key_i   (probe_key),
    .match_o (match)
  );

  // request beat taken with a known code starts a probe
  assign probe_start = start && !busy &&
                       (req_i.req_type == REQ_INSERT || req_i.req_type == REQ_SEARCH ||
                        req_i.req_type == REQ_REMOVE);

  // found value is zero on every other result beat
  assign value_ok = !done_o || (rsp_o.status == ST_FOUND) || (rsp_o.found_value == '0);

  // checks
  `ASSERT_NEVER(a_done_while_busy, done_o && busy, "result beat while busy")
  `ASSERT_HOLDS(a_accept_goes_busy, probe_start |=> busy, "accepted request did not start a probe")
  `ASSERT_HOLDS(a_value_only_on_found, value_ok, "found value on a non-found result")
  `ASSERT_NEVER(a_write_when_idle, wr_en && !busy, "slot write outside a probe")

endmodule

### verif/tb.sv
// self-checking testbench for linear_probe_hash_map_core: directed and random request beats
// depends on hmap_pkg for the request and result types and the table geometry
`timescale 1ns / 100ps

module tb;
  import hmap_pkg::*;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam int         RANDOM_ITEMS   = 1200;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 150;

  logic   clk_i  = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start  = 1'b0;
  logic   busy;
  req_t   req_i  = '0;
  logic   done_o;
  rsp_t   rsp_o;

  // request beats waiting to be driven, results owed by the block
  req_t   req_backlog[$];
  rsp_t   rsp_due[$];

  // shadow copy of the slot store
  tag_e                        tag_mem [Slots];
  logic [KeyBits-1:0]          key_mem [Slots];
  logic signed [ValueBits-1:0] val_mem [Slots];

  // keys the stimulus generator believes are stored
  logic [KeyBits-1:0] live_keys[$];

  int beats_in    = 0;
  int fail_cnt    = 0;
  int idle_cycles = 0;

  linear_probe_hash_map_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // apply one request to the shadow store and return the result it must give
  function automatic rsp_t apply_request(input req_t r);
    rsp_t        o;
    int unsigned s, hit, free_idx;
    bit          found, has_free;
    o.status      = ST_MISSING;
    o.found_value = '0;
    found         = 1'b0;
    has_free      = 1'b0;
    hit           = 0;
    free_idx      = 0;
    s             = r.key % Slots;
    // walk at most one lap from the home slot
    for (int n = 0; n < Slots; n++) begin
      if (tag_mem[s] == TAG_EMPTY) begin
        if (!has_free) begin
          has_free = 1'b1;
          free_idx = s;
        end
        break;
      end
      if (tag_mem[s] == TAG_USED && key_mem[s] == r.key) begin
        found = 1'b1;
        hit   = s;
        break;
      end
      if (tag_mem[s] == TAG_DELETED && !has_free) begin
        has_free = 1'b1;
        free_idx = s;
      end
      s = (s + 1) % Slots;
    end
    case (r.req_type)
      REQ_INSERT: begin
        if (found) begin
          val_mem[hit] = r.value;
          o.status     = ST_STORED;
        end else if (has_free) begin
          tag_mem[free_idx] = TAG_USED;
          key_mem[free_idx] = r.key;
          val_mem[free_idx] = r.value;
          o.status          = ST_STORED;
        end else begin
          o.status = ST_FULL;
        end
      end
      REQ_SEARCH: begin
        if (found) begin
          o.status      = ST_FOUND;
          o.found_value = val_mem[hit];
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          tag_mem[hit] = TAG_DELETED;
          o.status     = ST_REMOVED;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int live_index(input logic [KeyBits-1:0] k);
    foreach (live_keys[i]) begin
      if (live_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // key not currently stored, optionally with its home slot near a cluster
  function automatic logic [KeyBits-1:0] fresh_key(input int unsigned home, input bit clustered);
    logic [KeyBits-1:0] k;
    do begin
      k = $urandom();
      if (clustered) k[SlotBits-1:0] = SlotBits'(home + $urandom_range(0, 3));
    end while (live_index(k) >= 0);
    return k;
  endfunction

  function automatic logic [KeyBits-1:0] any_live_key();
    return live_keys[$urandom_range(0, live_keys.size() - 1)];
  endfunction

  // queue one beat and keep the generator's view of the stored keys
  task automatic enqueue(input req_e op, input logic [KeyBits-1:0] k,
                         input logic signed [ValueBits-1:0] v);
    req_t r;
    int   idx;
    r.req_type = op;
    r.key      = k;
    r.value    = v;
    req_backlog.push_back(r);
    idx = live_index(k);
    if (op == REQ_INSERT && idx < 0 && live_keys.size() < Slots) live_keys.push_back(k);
    else if (op == REQ_REMOVE && idx >= 0) live_keys.delete(idx);
  endtask

  // mixed traffic around one cluster, with some noise
  task automatic mixed_round(input int unsigned n);
    int unsigned        home, pick;
    logic [KeyBits-1:0] k;
    home = ($urandom_range(0, 2) == 0) ? Slots - 2 : $urandom_range(0, Slots - 1);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (live_keys.size() != 0 && $urandom_range(0, 1) == 1) k = any_live_key();
      else k = fresh_key(home, $urandom_range(0, 3) != 0);
      if (pick < 40)      enqueue(REQ_INSERT, k, $urandom());
      else if (pick < 70) enqueue(REQ_SEARCH, k, $urandom());
      else if (pick < 95) enqueue(REQ_REMOVE, k, $urandom());
      else                enqueue(req_e'(REQ_UNUSED), k, $urandom());
    end
  endtask

  // fill the table, hit it while full, then drain most of it
  task automatic fill_round();
    int unsigned home, target;
    home = $urandom_range(0, Slots - 1);
    while (live_keys.size() < Slots)
      enqueue(REQ_INSERT, fresh_key(home, $urandom_range(0, 4) < 2), $urandom());
    for (int i = 0; i < 12; i++) enqueue(REQ_INSERT, fresh_key(home, i % 2), $urandom());
    for (int i = 0; i < 8; i++)  enqueue(REQ_SEARCH, fresh_key(home, i % 2), $urandom());
    for (int i = 0; i < 4; i++)  enqueue(REQ_REMOVE, fresh_key(home, i % 2), $urandom());
    for (int i = 0; i < 16; i++)
      enqueue((i < 10) ? REQ_SEARCH : REQ_INSERT, any_live_key(), $urandom());
    for (int i = 0; i < 3; i++)  enqueue(req_e'(REQ_UNUSED), $urandom(), $urandom());
    target = $urandom_range(0, 20);
    while (live_keys.size() > target) begin
      if ($urandom_range(0, 4) == 0) enqueue(REQ_SEARCH, any_live_key(), $urandom());
      else                           enqueue(REQ_REMOVE, any_live_key(), $urandom());
    end
  endtask

  // stimulus, reset and end of run
  initial begin : stim
    int unsigned round_no;
    int unsigned total;
    foreach (tag_mem[i]) tag_mem[i] = TAG_EMPTY;

    // directed: collisions, wraparound, update, tombstones, unused code, extremes
    enqueue(REQ_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
    enqueue(REQ_INSERT, 32'h0000_0080, 32'h8000_0000);
    enqueue(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    enqueue(REQ_INSERT, 32'h0000_007F, 32'h0000_0005);
    enqueue(REQ_SEARCH, 32'h0000_007F, 32'h0000_0000);
    enqueue(REQ_SEARCH, 32'h0000_0100, 32'h0000_0000);
    enqueue(REQ_INSERT, 32'h0000_0000, 32'h0000_007B);
    enqueue(REQ_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF);
    enqueue(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
    enqueue(REQ_SEARCH, 32'h0000_0080, 32'h0000_0000);
    enqueue(REQ_INSERT, 32'h0000_0080, 32'h0000_004D);
    enqueue(REQ_SEARCH, 32'h0000_0000, 32'h0000_0000);
    enqueue(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
    enqueue(REQ_INSERT, 32'h0000_0100, 32'h0000_002A);
    enqueue(REQ_SEARCH, 32'h0000_0100, 32'h0000_0000);
    enqueue(req_e'(REQ_UNUSED), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    enqueue(REQ_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    enqueue(REQ_REMOVE, 32'h0000_007F, 32'h0000_0000);
    enqueue(REQ_SEARCH, 32'h0000_007F, 32'h0000_0000);
    enqueue(REQ_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    enqueue(REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    enqueue(REQ_SEARCH, 32'hAAAA_AAAA, 32'h0000_0000);
    enqueue(REQ_SEARCH, 32'h5555_5555, 32'h0000_0000);
    enqueue(REQ_SEARCH, 32'h0000_0080, 32'h0000_0000);

    // random rounds; a fill round only while there is room for one
    total    = req_backlog.size() + RANDOM_ITEMS;
    round_no = 0;
    while (req_backlog.size() < total) begin
      if (round_no % 5 == 1 && total - req_backlog.size() > 300) fill_round();
      else                                                        mixed_round(60);
      round_no++;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the last request to go in and its result to come back
    while (req_backlog.size() != 0 || start || rsp_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** linear_probe_hash_map_core: PASSED **");
    end else begin
      $display("** linear_probe_hash_map_core: FAILED **");
    end
    $finish;
  end

  // driver: record accepted beats, then offer the next one or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        rsp_due.push_back(apply_request(req_i));
        beats_in++;
      end
      if (!(start && busy)) begin
        if (req_backlog.size() != 0 &&
            ((beats_in >= 300 && beats_in < 600) || $urandom_range(0, 99) >= 17)) begin
          start <= 1'b1;
          req_i <= req_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest owed result
  always @(posedge clk_i) begin : mon
    rsp_t want;
    if (rst_ni && done_o) begin
      if (rsp_due.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_cnt++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_o.status);
          fail_cnt++;
        end
        if (rsp_o.found_value !== want.found_value) begin
          $error("found_value: expected %0d, got %0d", want.found_value, rsp_o.found_value);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** linear_probe_hash_map_core: FAILED **");
        $finish;
      end
    end
  end

endmodule
